@@ rtl/mi3_pkg.sv @@
package mi3_pkg;

  localparam int ElemW  = 16;
  localparam int CofW   = 2 * ElemW + 1;
  localparam int DetW   = 3 * ElemW + 2;
  localparam int QuotW  = 32;
  localparam int NumW   = CofW + 24;
  localparam int MagW   = DetW;
  localparam int DivLat = NumW;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [QuotW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [QuotW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [QuotW-1:0] SatNeg = 32'h8000_0000;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;

  typedef struct packed {
    cof_t [8:0] cof;
    det_t       det;
  } job_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] num;
    logic [MagW-1:0] den;
    logic            neg;
  } div_t;

  typedef struct packed {
    logic [8:0][QuotW-1:0] inv;
    logic                  singular;
  } res_t;

endpackage

@@ rtl/mi3_front.sv @@
module mi3_front import mi3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  elem_t [8:0] x,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  // stage 1: cofactors; product stage: column-0 products; stage 2: determinant
  logic        s1_vld_r, s2_vld_r;
  logic        s1_en, s2_en;
  cof_t [8:0]  cof_r, cof2_r;
  elem_t [2:0] col0_r;
  logic signed [DetW-1:0] p0_r, p1_r, p2_r;
  logic        p_vld_r, p_en;

  function automatic cof_t cf(elem_t a, elem_t b, elem_t c, elem_t d);
    logic signed [2*ElemW-1:0] m0, m1;
    begin
      m0 = a * b;
      m1 = c * d;
      cf = CofW'(m0) - CofW'(m1);
    end
  endfunction

  assign s2_en    = !s2_vld_r || job_ready;
  assign p_en     = !p_vld_r || s2_en;
  assign s1_en    = !s1_vld_r || p_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      p_vld_r  <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_valid;
      if (p_en)  p_vld_r  <= s1_vld_r;
      if (s2_en) s2_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      cof_r[0] <= cf(x[4], x[8], x[7], x[5]);
      cof_r[1] <= cf(x[7], x[2], x[1], x[8]);
      cof_r[2] <= cf(x[1], x[5], x[4], x[2]);
      cof_r[3] <= cf(x[6], x[5], x[3], x[8]);
      cof_r[4] <= cf(x[0], x[8], x[6], x[2]);
      cof_r[5] <= cf(x[3], x[2], x[0], x[5]);
      cof_r[6] <= cf(x[3], x[7], x[6], x[4]);
      cof_r[7] <= cf(x[6], x[1], x[0], x[7]);
      cof_r[8] <= cf(x[0], x[4], x[3], x[1]);
      col0_r   <= {x[6], x[3], x[0]};
    end
    if (p_en) begin
      p0_r   <= DetW'(col0_r[0] * cof_r[0]);
      p1_r   <= DetW'(col0_r[1] * cof_r[1]);
      p2_r   <= DetW'(col0_r[2] * cof_r[2]);
      cof2_r <= cof_r;
    end
    if (s2_en) begin
      job.det <= p0_r + p1_r + p2_r;
      job.cof <= cof2_r;
    end
  end

  assign job_valid = s2_vld_r;

endmodule

@@ rtl/mi3_queue.sv @@
module mi3_queue import mi3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t [QDepth-1:0] mem_r;
  logic [QPtrW-1:0]  wp_r, rp_r;
  logic [QPtrW:0]    cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (QPtrW+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

@@ rtl/mi3_back.sv @@
module mi3_back import mi3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // pipelined restoring divider, one quotient bit per stage, nine lanes
  logic [DivLat:0]          vld_r;
  logic [DivLat:0]          sing_r;
  div_t [DivLat:0][8:0]     st_r;
  logic                     adv;
  logic [MagW-1:0]          dmag;
  logic                     dz;

  assign adv       = !vld_r[DivLat] || res_ready;
  assign job_ready = adv;
  assign dz        = job.det == '0;
  assign dmag      = job.det[DetW-1] ? MagW'(-job.det) : MagW'(job.det);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DivLat-1:0], job_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= {sing_r[DivLat-1:0], dz};
      for (int k = 0; k < 9; k++) begin
        st_r[0][k].rem <= '0;
        st_r[0][k].num <= {(job.cof[k][CofW-1] ? CofW'(-job.cof[k]) : CofW'(job.cof[k])),
                           24'd0};
        st_r[0][k].den <= dmag;
        st_r[0][k].neg <= job.cof[k][CofW-1] ^ job.det[DetW-1];
      end
      for (int s = 0; s < DivLat; s++) begin
        for (int k = 0; k < 9; k++) begin
          logic [NumW:0] t;
          t = {st_r[s][k].rem, st_r[s][k].num[NumW-1]};
          if (t >= (NumW+1)'(st_r[s][k].den)) begin
            st_r[s+1][k].rem <= NumW'(t - (NumW+1)'(st_r[s][k].den));
            st_r[s+1][k].num <= {st_r[s][k].num[NumW-2:0], 1'b1};
          end else begin
            st_r[s+1][k].rem <= NumW'(t);
            st_r[s+1][k].num <= {st_r[s][k].num[NumW-2:0], 1'b0};
          end
          st_r[s+1][k].den <= st_r[s][k].den;
          st_r[s+1][k].neg <= st_r[s][k].neg;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic [NumW-1:0] q;
      q = st_r[DivLat][k].num;
      if (sing_r[DivLat]) begin
        res.inv[k] = (k == 0 || k == 4 || k == 8) ? OneQ16 : '0;
      end else if (st_r[DivLat][k].neg) begin
        res.inv[k] = (q > NumW'(SatNeg)) ? SatNeg : QuotW'(-q);
      end else begin
        res.inv[k] = (q > NumW'(SatPos)) ? SatPos : QuotW'(q);
      end
    end
    res.singular = sing_r[DivLat];
  end

  assign res_valid = vld_r[DivLat];

endmodule

@@ rtl/matrix_inverse_3x3_top.sv @@
// 3x3 matrix inverse by adjugate over determinant, Q8.8 in, Q16.16 out, saturated.
// Takes one matrix per cycle while in_ready is high. The path runs through three
// stages of cofactor and determinant products, a four-deep word queue, then a
// 57-stage restoring divider (one quotient bit per stage, nine lanes).
// A zero determinant returns identity with singular set.
module matrix_inverse_3x3_top import mi3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  elem_t        in_a_c0_r0, in_a_c0_r1, in_a_c0_r2,
  input  elem_t        in_a_c1_r0, in_a_c1_r1, in_a_c1_r2,
  input  elem_t        in_a_c2_r0, in_a_c2_r1, in_a_c2_r2,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_inv_c0_r0, out_inv_c0_r1, out_inv_c0_r2,
  output logic [31:0]  out_inv_c1_r0, out_inv_c1_r1, out_inv_c1_r2,
  output logic [31:0]  out_inv_c2_r0, out_inv_c2_r1, out_inv_c2_r2,
  output logic         out_singular
);

  job_t f_job, q_job;
  logic f_vld, f_rdy, q_vld, q_rdy;
  res_t res;

  mi3_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .x({in_a_c2_r2, in_a_c2_r1, in_a_c2_r0, in_a_c1_r2, in_a_c1_r1, in_a_c1_r0,
        in_a_c0_r2, in_a_c0_r1, in_a_c0_r0}),
    .job_valid(f_vld), .job_ready(f_rdy), .job(f_job)
  );

  mi3_queue u_queue (
    .clk, .rst_n, .wr_valid(f_vld), .wr_ready(f_rdy), .wr_data(f_job),
    .rd_valid(q_vld), .rd_ready(q_rdy), .rd_data(q_job)
  );

  mi3_back u_back (
    .clk, .rst_n, .job_valid(q_vld), .job_ready(q_rdy), .job(q_job),
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_inv_c0_r0 = res.inv[0];
  assign out_inv_c0_r1 = res.inv[1];
  assign out_inv_c0_r2 = res.inv[2];
  assign out_inv_c1_r0 = res.inv[3];
  assign out_inv_c1_r1 = res.inv[4];
  assign out_inv_c1_r2 = res.inv[5];
  assign out_inv_c2_r0 = res.inv[6];
  assign out_inv_c2_r1 = res.inv[7];
  assign out_inv_c2_r2 = res.inv[8];
  assign out_singular  = res.singular;

endmodule

@@ rtl/mi3_checker.sv @@
module mi3_checker import mi3_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_inv_c0_r0,
  input logic [31:0] out_inv_c1_r1,
  input logic [31:0] out_inv_c1_r0,
  input logic        out_singular
);

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inv_c0_r0) && $stable(out_singular))
    else $error("stalled result changed");

  // singular gives identity
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_c0_r0 == OneQ16 && out_inv_c1_r1 == OneQ16
      && out_inv_c1_r0 == '0)
    else $error("singular result not identity");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_inv_c0_r0, .out_inv_c1_r1,
  .out_inv_c1_r0, .out_singular
);
